/* sv/iefs_pkg.sv */
package iefs_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  localparam int unsigned SrcW  = 8;
  localparam int unsigned VecW  = 8;
  localparam int unsigned TimeW = 64;
  localparam int unsigned LatW  = 32;
  localparam int unsigned CntW  = 32;

  typedef struct packed {
    logic [SrcW-1:0]  source;
    logic [VecW-1:0]  vector;
    logic [TimeW-1:0] ts;
    logic [LatW-1:0]  latency;
  } rec_t;

endpackage

/* sv/interrupt_event_fifo_with_stats_unit.sv */
// Ring queue of deferred interrupt records with statistics. Each input beat is
// a push (store source, vector, timestamp and entry latency, or drop when the
// queue holds QUEUE_DEPTH records) or a pop (return the oldest record, or
// report empty). Records live in one memory of QUEUE_DEPTH entries with a
// registered read port. The block takes one beat per cycle unless stalled and
// delivers its result in the cycle after acceptance, read from the memory
// at acceptance. A result that waits on out_stall_i holds off the next input
// beat. pending_count, peak_pending and the three saturating totals reflect
// the state after the beat that produced the result. QUEUE_DEPTH must be a
// power of two.
module interrupt_event_fifo_with_stats_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic [7:0]                         irq_source_i,
  input  logic [7:0]                         irq_vector_i,
  input  logic [63:0]                        capture_time_i,
  input  logic [31:0]                        entry_latency_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output iefs_pkg::status_e                  status_o,
  output logic [7:0]                         out_source_o,
  output logic [7:0]                         out_vector_o,
  output logic [63:0]                        out_time_o,
  output logic [31:0]                        out_latency_o,
  output logic [$clog2(QUEUE_DEPTH):0]       pending_count_o,
  output logic [$clog2(QUEUE_DEPTH):0]       peak_pending_o,
  output logic [31:0]                        queued_total_o,
  output logic [31:0]                        dispatched_total_o,
  output logic [31:0]                        dropped_total_o
);
  import iefs_pkg::*;

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned PtrW  = AddrW + 1;

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] peak_q, peak_d;
  logic [PtrW-1:0] pending, pending_inc;
  logic [CntW-1:0] queued_q, queued_d, disp_q, disp_d, drop_q, drop_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  rec_t            mem_q [QUEUE_DEPTH];
  rec_t            rdata_q, wr_rec;
  logic            in_fire, is_push, full, empty, wr_en, rd_en;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign is_push     = (cmd_e'(command_i) == CMD_PUSH);
  assign pending     = wr_ptr_q - rd_ptr_q;
  assign pending_inc = pending + PtrW'(1);
  assign full        = (pending == PtrW'(QUEUE_DEPTH));
  assign empty       = (pending == '0);
  assign wr_en       = in_fire & is_push & ~full;
  assign rd_en       = in_fire & ~is_push & ~empty;

  assign wr_rec = '{source: irq_source_i, vector: irq_vector_i,
                    ts: capture_time_i, latency: entry_latency_i};

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    peak_d      = peak_q;
    queued_d    = queued_q;
    disp_d      = disp_q;
    drop_d      = drop_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (in_fire) begin
      out_valid_d = 1'b1;
      if (is_push) begin
        if (full) begin
          status_d = ST_DROPPED;
          if (drop_q != '1) drop_d = drop_q + CntW'(1);
        end else begin
          status_d = ST_PUSHED;
          wr_ptr_d = wr_ptr_q + PtrW'(1);
          if (queued_q != '1) queued_d = queued_q + CntW'(1);
          if (pending_inc > peak_q) peak_d = pending_inc;
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_POPPED;
          rd_ptr_d = rd_ptr_q + PtrW'(1);
          if (disp_q != '1) disp_d = disp_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      peak_q      <= '0;
      queued_q    <= '0;
      disp_q      <= '0;
      drop_q      <= '0;
      status_q    <= ST_PUSHED;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      peak_q      <= peak_d;
      queued_q    <= queued_d;
      disp_q      <= disp_d;
      drop_q      <= drop_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Record store: read data holds until the next pop from a non-empty queue is accepted.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q[AddrW-1:0]] <= wr_rec;
    if (rd_en) rdata_q <= mem_q[rd_ptr_q[AddrW-1:0]];
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign out_source_o       = (status_q == ST_POPPED) ? rdata_q.source  : '0;
  assign out_vector_o       = (status_q == ST_POPPED) ? rdata_q.vector  : '0;
  assign out_time_o         = (status_q == ST_POPPED) ? rdata_q.ts      : '0;
  assign out_latency_o      = (status_q == ST_POPPED) ? rdata_q.latency : '0;
  assign pending_count_o    = pending;
  assign peak_pending_o     = peak_q;
  assign queued_total_o     = queued_q;
  assign dispatched_total_o = disp_q;
  assign dropped_total_o    = drop_q;

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= PtrW'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= pending)
    else $error("peak below current pending count");

  a_push_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (wr_ptr_q == $past(wr_ptr_q) + PtrW'(1)) && (status_q == ST_PUSHED))
    else $error("accepted push did not advance write pointer");

  a_drop_holds_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_push && full) |=> $stable(wr_ptr_q) && (status_q == ST_DROPPED))
    else $error("dropped push changed write pointer");

endmodule
